// ===== rtl/core/qks_pkg.sv =====
// Shared types, constants and helpers for the quadrant key-point selector.
package qks_pkg;

  localparam int FRAC_BITS = 4;
  localparam int ID_WIDTH  = 16;
  localparam int NUM_SLOTS = 5;

  localparam int FID_W     = 16;
  localparam int COORD_W   = 16;
  localparam int CFG_W     = 12;
  localparam int CFG_IDX_W = 1;
  localparam int SLOT_IDX_W = $clog2(NUM_SLOTS);
  localparam int OP_W      = 2;

  // Internal compare width holds both a coordinate and a promoted centre.
  localparam int CW = COORD_W + FRAC_BITS;
  localparam int PW = 2 * CW;

  localparam logic [FID_W-1:0] ID_MASK =
    (ID_WIDTH >= FID_W) ? {FID_W{1'b1}} : FID_W'((64'd1 << ID_WIDTH) - 64'd1);

  localparam logic [CFG_W-1:0] CENTER_U_RST = CFG_W'(320);
  localparam logic [CFG_W-1:0] CENTER_V_RST = CFG_W'(240);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_U = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_V = CFG_IDX_W'(1);

  // Slot numbers
  localparam logic [SLOT_IDX_W-1:0] SLOT_CENTER      = SLOT_IDX_W'(0);
  localparam logic [SLOT_IDX_W-1:0] SLOT_RIGHT_LOWER = SLOT_IDX_W'(1);
  localparam logic [SLOT_IDX_W-1:0] SLOT_RIGHT_UPPER = SLOT_IDX_W'(2);
  localparam logic [SLOT_IDX_W-1:0] SLOT_LEFT_UPPER  = SLOT_IDX_W'(3);
  localparam logic [SLOT_IDX_W-1:0] SLOT_LEFT_LOWER  = SLOT_IDX_W'(4);

  typedef enum logic [OP_W-1:0] {
    OP_OFFER = 2'd0,
    OP_DROP  = 2'd1,
    OP_READ  = 2'd2
  } op_t;

  typedef struct packed {
    logic [FID_W-1:0]   id;
    logic [COORD_W-1:0] u;
    logic [COORD_W-1:0] v;
  } slot_t;

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [FID_W-1:0]      feature_id;
    logic [COORD_W-1:0]    px_u;
    logic [COORD_W-1:0]    px_v;
    logic [SLOT_IDX_W-1:0] slot_index;
  } item_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] take;
    logic [NUM_SLOTS-1:0] clear;
    slot_t                feat;
  } upd_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] updated_mask;
    logic                 dropped;
    logic                 slot_valid;
    slot_t                slot;
  } res_t;

  function automatic logic [CW-1:0] abs_diff(input logic [CW-1:0] a, input logic [CW-1:0] b);
    abs_diff = (a >= b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/core/qks_if.sv =====
// Valid/ready channel interfaces for the selector's item and result words.
interface qks_in_if import qks_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [OP_W-1:0]       op;
  logic [FID_W-1:0]      feature_id;
  logic [COORD_W-1:0]    px_u;
  logic [COORD_W-1:0]    px_v;
  logic [SLOT_IDX_W-1:0] slot_index;

  modport source(output valid, op, feature_id, px_u, px_v, slot_index, input ready);
  modport sink(input valid, op, feature_id, px_u, px_v, slot_index, output ready);
endinterface

interface qks_out_if import qks_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [NUM_SLOTS-1:0] updated_mask;
  logic                 dropped;
  logic                 slot_valid;
  logic [FID_W-1:0]     slot_feature_id;
  logic [COORD_W-1:0]   slot_u;
  logic [COORD_W-1:0]   slot_v;

  modport source(output valid, updated_mask, dropped, slot_valid, slot_feature_id,
                 slot_u, slot_v, input ready);
  modport sink(input valid, updated_mask, dropped, slot_valid, slot_feature_id,
               slot_u, slot_v, output ready);
endinterface

// ===== rtl/core/qks_eval.sv =====
// Per-item decision logic: slot comparisons, drop match and slot read.
module qks_eval import qks_pkg::*; (
  input  item_t                       item,
  input  logic [CFG_W-1:0]            center_u,
  input  logic [CFG_W-1:0]            center_v,
  input  logic [NUM_SLOTS-1:0]        held_valid,
  input  slot_t [NUM_SLOTS-1:0]       held,
  output upd_t                        upd,
  output res_t                        res
);

  logic [CW-1:0]         cu, cv, fu, fv;
  logic [CW-1:0]         du, dv, cheb_new;
  logic [CW-1:0]         hdu, hdv, cheb_held;
  logic [CW-1:0]         qdu, qdv;
  logic [PW-1:0]         area_new, area_held;
  logic                  right, lower;
  logic [SLOT_IDX_W-1:0] quad;
  logic                  q_valid;
  slot_t                 q_slot;
  logic                  r_valid;
  slot_t                 r_slot;
  logic [FID_W-1:0]      id_m;
  logic [NUM_SLOTS-1:0]  offer_mask, drop_mask;

  assign cu   = CW'(center_u) << FRAC_BITS;
  assign cv   = CW'(center_v) << FRAC_BITS;
  assign fu   = CW'(item.px_u);
  assign fv   = CW'(item.px_v);
  assign id_m = item.feature_id & ID_MASK;

  assign du       = abs_diff(fu, cu);
  assign dv       = abs_diff(fv, cv);
  assign cheb_new = (du > dv) ? du : dv;

  assign hdu       = abs_diff(CW'(held[SLOT_CENTER].u), cu);
  assign hdv       = abs_diff(CW'(held[SLOT_CENTER].v), cv);
  assign cheb_held = (hdu > hdv) ? hdu : hdv;

  assign right = fu >= cu;
  assign lower = fv >= cv;

  always_comb begin
    if (right && lower) begin
      quad = SLOT_RIGHT_LOWER;
    end else if (right) begin
      quad = SLOT_RIGHT_UPPER;
    end else if (!lower) begin
      quad = SLOT_LEFT_UPPER;
    end else begin
      quad = SLOT_LEFT_LOWER;
    end
  end

  // Held feature of the target quadrant and of the read slot
  always_comb begin
    q_valid = 1'b0;
    q_slot  = '0;
    r_valid = 1'b0;
    r_slot  = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (quad == SLOT_IDX_W'(k)) begin
        q_valid = held_valid[k];
        q_slot  = held[k];
      end
      if (item.slot_index == SLOT_IDX_W'(k)) begin
        r_valid = held_valid[k];
        r_slot  = held[k];
      end
    end
  end

  assign qdu       = abs_diff(CW'(q_slot.u), cu);
  assign qdv       = abs_diff(CW'(q_slot.v), cv);
  assign area_new  = du * dv;
  assign area_held = qdu * qdv;

  always_comb begin
    offer_mask = '0;
    if (!held_valid[SLOT_CENTER] || (cheb_new < cheb_held)) begin
      offer_mask[SLOT_CENTER] = 1'b1;
    end
    if (!q_valid || (area_new > area_held)) begin
      offer_mask[quad] = 1'b1;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      drop_mask[k] = held_valid[k] && (held[k].id == id_m);
    end
  end

  always_comb begin
    upd           = '0;
    upd.feat.id   = id_m;
    upd.feat.u    = item.px_u;
    upd.feat.v    = item.px_v;
    res           = '0;
    case (item.op)
      OP_OFFER: begin
        upd.take         = offer_mask;
        res.updated_mask = offer_mask;
      end
      OP_DROP: begin
        upd.clear        = drop_mask;
        res.updated_mask = drop_mask;
        res.dropped      = |drop_mask;
      end
      OP_READ: begin
        if (r_valid) begin
          res.slot_valid = 1'b1;
          res.slot       = r_slot;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

// ===== rtl/core/qks_slots.sv =====
// Slot bank: five held key points with their valid bits.
module qks_slots import qks_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  upd_t                  upd,
  output logic [NUM_SLOTS-1:0]  held_valid,
  output slot_t [NUM_SLOTS-1:0] held
);

  logic [NUM_SLOTS-1:0]  valid_r, valid_nxt;
  slot_t [NUM_SLOTS-1:0] slot_r;

  assign valid_nxt = (valid_r & ~upd.clear) | upd.take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (en) begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (en && upd.take[k]) begin
        slot_r[k] <= upd.feat;
      end
    end
  end

  assign held_valid = valid_r;
  assign held       = slot_r;

endmodule

// ===== rtl/core/quadrant_keypoint_selector.sv =====
// Top level: item register, decision logic, slot bank and result register.
// A word goes from the item register to the result register, which drives out_ch.
// Throughput: one word per cycle unless out_ch stalls; the slot bank is read
// and updated in the same cycle, so each word sees every earlier word's slot changes.
// Reset (rst_n low, synchronous): all slots empty, both pipeline stages empty,
// centre back to 320, 240.
module quadrant_keypoint_selector import qks_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  qks_in_if.sink               in_ch,
  qks_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  logic [CFG_W-1:0]      center_u_r, center_v_r;
  logic                  s_valid_r;
  item_t                 s_item_r;
  logic                  o_valid_r;
  res_t                  o_res_r;
  logic                  adv;
  upd_t                  upd;
  res_t                  res;
  logic [NUM_SLOTS-1:0]  held_valid;
  slot_t [NUM_SLOTS-1:0] held;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_u_r <= CENTER_U_RST;
      center_v_r <= CENTER_V_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CENTER_U: center_u_r <= cfg_wdata;
        CFG_CENTER_V: center_v_r <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign adv         = s_valid_r && (!o_valid_r || out_ch.ready);
  assign in_ch.ready = !s_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s_item_r.op         <= in_ch.op;
      s_item_r.feature_id <= in_ch.feature_id;
      s_item_r.px_u       <= in_ch.px_u;
      s_item_r.px_v       <= in_ch.px_v;
      s_item_r.slot_index <= in_ch.slot_index;
    end
  end

  qks_eval u_eval (
    .item       (s_item_r),
    .center_u   (center_u_r),
    .center_v   (center_v_r),
    .held_valid (held_valid),
    .held       (held),
    .upd        (upd),
    .res        (res)
  );

  qks_slots u_slots (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .upd        (upd),
    .held_valid (held_valid),
    .held       (held)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      o_valid_r <= 1'b0;
    end else if (!o_valid_r || out_ch.ready) begin
      o_valid_r <= s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      o_res_r <= res;
    end
  end

  assign out_ch.valid           = o_valid_r;
  assign out_ch.updated_mask    = o_res_r.updated_mask;
  assign out_ch.dropped         = o_res_r.dropped;
  assign out_ch.slot_valid      = o_res_r.slot_valid;
  assign out_ch.slot_feature_id = o_res_r.slot.id;
  assign out_ch.slot_u          = o_res_r.slot.u;
  assign out_ch.slot_v          = o_res_r.slot.v;

  // A slot taken by an offer is occupied afterwards
  a_take_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (upd.take != '0)) |=> ((held_valid & $past(upd.take)) == $past(upd.take)))
    else $error("taken slot not marked valid");

  // A drop leaves no slot that held the dropped id
  a_drop_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && (upd.clear != '0)) |=> ((held_valid & $past(upd.clear)) == '0))
    else $error("dropped slot still valid");

  // A read result never reports slot changes
  a_read_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_res_r.slot_valid) |-> (o_res_r.updated_mask == '0 && !o_res_r.dropped))
    else $error("read result carries an update mask");

  // An offer touches at most the centre slot and one quadrant slot
  a_offer_two_slots: assert property (@(posedge clk) disable iff (!rst_n)
    adv |-> ($countones(upd.take) <= 2))
    else $error("offer takes too many slots");

  // An empty result register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !o_valid_r |-> in_ch.ready)
    else $error("input stalled with empty output stage");

endmodule
